// ===== rtl/swf_pkg.sv =====
// Shared constants, codes and types of the subsequence word filter.
`timescale 1ns / 1ps
`default_nettype none

package swf_pkg;

  // Table geometry
  localparam int MAX_WORDS = 64;
  localparam int MAX_LEN   = 32;

  // Byte index inside one word, and position/length (0..MAX_LEN)
  localparam int LEN_IDX_W = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int POS_W     = $clog2(MAX_LEN + 1);

  // Fixed result field widths
  localparam int MASK_W = 64;
  localparam int CNT_W  = 7;

  // Alive counting: groups of eight words, one small count per group
  localparam int GROUP_SIZE = 8;
  localparam int NGROUPS    = (MAX_WORDS + GROUP_SIZE - 1) / GROUP_SIZE;
  localparam int GCNT_W     = 4;

  // Command codes
  localparam logic [1:0] CMD_CLEAR = 2'd0;
  localparam logic [1:0] CMD_LOAD  = 2'd1;
  localparam logic [1:0] CMD_TYPE  = 2'd2;

  // Error codes
  localparam logic [1:0] ERR_OK   = 2'd0;
  localparam logic [1:0] ERR_FULL = 2'd1;
  localparam logic [1:0] ERR_LONG = 2'd2;

  // Broadcast from the control logic to every cell
  typedef struct packed {
    logic                 clear;
    logic                 load_we;
    logic                 commit;
    logic                 type_en;
    logic [7:0]           data;
    logic [LEN_IDX_W-1:0] wr_idx;
    logic [POS_W-1:0]     commit_len;
  } cell_ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/swf_cell.sv =====
// One word slot: stored bytes, length, match position and alive mark.
`timescale 1ns / 1ps
`default_nettype none

module swf_cell (
  input  logic              clk,
  input  logic              rst,
  input  swf_pkg::cell_ctrl_t ctrl,
  input  logic              prev_occ,
  output logic              occ,
  output logic              alive
);
  import swf_pkg::*;

  logic [7:0]       chars [MAX_LEN];
  logic [POS_W-1:0] len;
  logic [POS_W-1:0] pos;
  logic             target;
  logic [MAX_LEN-1:0] hit_vec;
  logic             hit;
  logic [POS_W-1:0] hit_pos;

  // The first free slot after the filled ones takes the word being loaded
  assign target = prev_occ & ~occ;

  // Compare the letter against every byte from the match position to the end
  always_comb begin
    for (int j = 0; j < MAX_LEN; j++) begin
      hit_vec[j] = (POS_W'(j) >= pos) && (POS_W'(j) < len) && (chars[j] == ctrl.data);
    end
  end

  // Pick the earliest hit; the new position lies just past it
  always_comb begin
    hit     = |hit_vec;
    hit_pos = '0;
    for (int j = MAX_LEN - 1; j >= 0; j--) begin
      if (hit_vec[j]) begin
        hit_pos = POS_W'(j + 1);
      end
    end
  end

  // Slot control: clear, commit, advance or drop
  always_ff @(posedge clk) begin
    if (rst) begin
      occ   <= 1'b0;
      alive <= 1'b0;
      pos   <= '0;
    end else if (ctrl.clear) begin
      occ   <= 1'b0;
      alive <= 1'b0;
      pos   <= '0;
    end else if (ctrl.commit && target) begin
      occ   <= 1'b1;
      alive <= 1'b1;
      pos   <= '0;
    end else if (ctrl.type_en && alive) begin
      if (hit) begin
        pos <= hit_pos;
      end else begin
        alive <= 1'b0;
      end
    end
  end

  // Word bytes and committed length
  always_ff @(posedge clk) begin
    if (ctrl.load_we && target) begin
      chars[ctrl.wr_idx] <= ctrl.data;
    end
    if (ctrl.commit && target) begin
      len <= ctrl.commit_len;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/subsequence_word_filter.sv =====
// Top level: load/type control, row of word cells, alive counting and result register.
//
//   channel | direction | handshake            | fields
//   --------+-----------+----------------------+-------------------------------------------
//   input   | in        | in_valid / in_ready  | command, char_byte, last_char
//   result  | out       | out_valid / out_ready| alive_mask, alive_count, stored_count, error
//
// Each input passes through the cells, which update on the accepting edge; the
// next edge registers per-group alive counts, and the sum stage adds them into the
// result register. A new input is taken once the count stages are empty,
// even while the previous result still waits. A stalled result holds the
// sum stage and with it the input. Reset clears all words and counters.
`timescale 1ns / 1ps
`default_nettype none

module subsequence_word_filter (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  command,
  input  logic [7:0]  char_byte,
  input  logic        last_char,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [swf_pkg::MASK_W-1:0] alive_mask,
  output logic [swf_pkg::CNT_W-1:0]  alive_count,
  output logic [swf_pkg::CNT_W-1:0]  stored_count,
  output logic [1:0]  error
);
  import swf_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_COUNT = 3'b010,
    ST_SUM   = 3'b100
  } state_t;

  state_t           state;
  state_t           state_next;
  logic [CNT_W-1:0] stored_words;
  logic [CNT_W-1:0] stored_words_next;
  logic [POS_W-1:0] load_length;
  logic [POS_W-1:0] load_length_next;
  logic [1:0]       err_hold;
  logic [1:0]       err_next;
  cell_ctrl_t       ctrl;
  logic             in_acc;
  logic             full;
  logic             len_full;
  logic             out_load;

  logic [MAX_WORDS-1:0]          occ_vec;
  logic [MAX_WORDS-1:0]          alive_vec;
  logic [NGROUPS*GROUP_SIZE-1:0] alive_pad;
  logic [MASK_W-1:0]             mask_s;
  logic [GCNT_W-1:0]             gcnt [NGROUPS];
  logic [GCNT_W-1:0]             gcnt_next [NGROUPS];
  logic [CNT_W-1:0]              count_sum;

  assign in_ready = (state == ST_IDLE);
  assign in_acc   = in_valid & in_ready;
  assign full     = (stored_words == CNT_W'(MAX_WORDS));
  assign len_full = (load_length == POS_W'(MAX_LEN));
  assign out_load = (state == ST_SUM) && (!out_valid || out_ready);

  // Decode the input into the cell broadcast and the table counters
  always_comb begin
    ctrl              = '0;
    ctrl.data         = char_byte;
    ctrl.wr_idx       = load_length[LEN_IDX_W-1:0];
    ctrl.commit_len   = len_full ? load_length : load_length + POS_W'(1);
    err_next          = ERR_OK;
    stored_words_next = stored_words;
    load_length_next  = load_length;
    if (in_acc) begin
      case (command)
        CMD_CLEAR: begin
          ctrl.clear        = 1'b1;
          stored_words_next = '0;
          load_length_next  = '0;
        end
        CMD_LOAD: begin
          if (full) begin
            err_next = ERR_FULL;
          end else begin
            if (!len_full) begin
              ctrl.load_we     = 1'b1;
              load_length_next = load_length + POS_W'(1);
            end else begin
              err_next = ERR_LONG;
            end
            if (last_char) begin
              ctrl.commit       = 1'b1;
              stored_words_next = stored_words + CNT_W'(1);
              load_length_next  = '0;
            end
          end
        end
        CMD_TYPE: begin
          ctrl.type_en = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  // Row of word cells; each hands its filled mark to the next
  for (genvar i = 0; i < MAX_WORDS; i++) begin : g_cell
    logic prev_occ;
    if (i == 0) begin : g_first
      assign prev_occ = 1'b1;
    end else begin : g_rest
      assign prev_occ = occ_vec[i-1];
    end
    swf_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctrl     (ctrl),
      .prev_occ (prev_occ),
      .occ      (occ_vec[i]),
      .alive    (alive_vec[i])
    );
  end

  // Count alive words per group of eight
  always_comb begin
    alive_pad                  = '0;
    alive_pad[MAX_WORDS-1:0]   = alive_vec;
    for (int g = 0; g < NGROUPS; g++) begin
      gcnt_next[g] = '0;
      for (int b = 0; b < GROUP_SIZE; b++) begin
        gcnt_next[g] = gcnt_next[g] + GCNT_W'(alive_pad[g*GROUP_SIZE + b]);
      end
    end
  end

  // Add up the group counts
  always_comb begin
    count_sum = '0;
    for (int g = 0; g < NGROUPS; g++) begin
      count_sum = count_sum + CNT_W'(gcnt[g]);
    end
  end

  // Sequence one input through update, group count and sum
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (in_acc) state_next = ST_COUNT;
      ST_COUNT: state_next = ST_SUM;
      ST_SUM:   if (out_load) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      stored_words <= '0;
      load_length  <= '0;
      out_valid    <= 1'b0;
    end else begin
      state        <= state_next;
      stored_words <= stored_words_next;
      load_length  <= load_length_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers: error code, snapshot, group counts, result
  always_ff @(posedge clk) begin
    if (in_acc) begin
      err_hold <= err_next;
    end
    if (state == ST_COUNT) begin
      mask_s <= MASK_W'(alive_vec);
      for (int g = 0; g < NGROUPS; g++) begin
        gcnt[g] <= gcnt_next[g];
      end
    end
    if (out_load) begin
      alive_mask   <= mask_s;
      alive_count  <= count_sum;
      stored_count <= stored_words;
      error        <= err_hold;
    end
  end

  // Only filled slots can be alive
  assert property (@(posedge clk) disable iff (rst) (alive_vec & ~occ_vec) == '0)
    else $error("alive word in an empty slot");

  // Filled slots track the word counter
  assert property (@(posedge clk) disable iff (rst)
    $countones(occ_vec) == int'(stored_words))
    else $error("slot fill marks disagree with word count");

  // The word under load never exceeds the byte limit
  assert property (@(posedge clk) disable iff (rst) load_length <= POS_W'(MAX_LEN))
    else $error("load length past limit");

  // A result never counts more alive words than stored words
  assert property (@(posedge clk) disable iff (rst) out_valid |-> alive_count <= stored_count)
    else $error("alive count above word count");

  // The table never changes while an input is still being counted
  assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |=> $stable(stored_words))
    else $error("table changed during counting");

endmodule

`default_nettype wire
